@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by fractional_bin_downsampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of an implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Concurrent check of an invariant, disabled during reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

@@ hw/rtl/fbd_pkg.sv @@
//------------------------------------------------------------------------------
// fbd_pkg
// Shared constants and types for the fractional bin downsampler.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package fbd_pkg;
	localparam int MAX_BINS_DEF     = 1024;
	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int LANES            = 4;
	localparam int CNT_W            = 11;
	localparam int IDX_W            = 10;

	localparam logic [1:0] REG_ENABLE   = 2'd0;
	localparam logic [1:0] REG_IN_BINS  = 2'd1;
	localparam logic [1:0] REG_OUT_BINS = 2'd2;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;
endpackage
`default_nettype wire

@@ hw/rtl/fbd_stream_if.sv @@
//------------------------------------------------------------------------------
// fbd_stream_if
// Valid/ready channel carrying a generic payload.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface fbd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fbd_lane_div.sv @@
//------------------------------------------------------------------------------
// fbd_lane_div
// One lane: restoring divider of a signed sum by the bin count, rounded to
// nearest with ties away from zero, saturated to the sample range.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fbd_lane_div #(
	parameter int SAMPLE_WIDTH = fbd_pkg::SAMPLE_WIDTH_DEF,
	parameter int ACC_W        = 44,
	parameter int CNT_W        = fbd_pkg::CNT_W
) (
	input  wire logic                           clk,
	input  wire logic                           start,
	input  wire logic signed [ACC_W-1:0]        acc,
	input  wire logic        [CNT_W-1:0]        divisor,
	input  wire logic                           step,
	output logic signed      [SAMPLE_WIDTH-1:0] result
);
	localparam int MAG_W = ACC_W + 1;
	logic              neg_q;
	logic [MAG_W-1:0]  quo_q;
	logic [CNT_W:0]    rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [MAG_W-1:0]  mag;
	logic [CNT_W+1:0]  trial;
	logic [MAG_W:0]    q_wide;
	logic signed [MAG_W+1:0] sres;
	localparam logic signed [MAG_W+1:0] MAXV =
		(MAG_W+2)'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [MAG_W+1:0] MINV = -MAXV - (MAG_W+2)'(1);

	always_comb begin
		mag = acc[ACC_W-1] ? MAG_W'(-{acc[ACC_W-1], acc}) : MAG_W'({1'b0, acc});
		trial = {rem_q, quo_q[MAG_W-1]} - {1'b0, 1'b0, div_q};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= acc[ACC_W-1];
			quo_q <= mag + MAG_W'(divisor >> 1);
			rem_q <= '0;
			div_q <= divisor;
		end else if (step) begin
			if (!trial[CNT_W+1]) begin
				rem_q <= trial[CNT_W:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[CNT_W-1:0], quo_q[MAG_W-1]};
				quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		q_wide = {1'b0, quo_q};
		sres = neg_q ? -$signed({1'b0, q_wide}) : $signed({1'b0, q_wide});
		if (sres > MAXV)
			result = SAMPLE_WIDTH'(MAXV);
		else if (sres < MINV)
			result = SAMPLE_WIDTH'(MINV);
		else
			result = SAMPLE_WIDTH'(sres);
	end
endmodule
`default_nettype wire

@@ hw/rtl/fractional_bin_downsampler.sv @@
//------------------------------------------------------------------------------
// fractional_bin_downsampler
// Area-averaging resampler of four-channel profiles with exact rational
// weights; four lanes accumulate and divide side by side.
//------------------------------------------------------------------------------
// Channel  Direction  Payload
// in_ch    sink       sample_i, sample_q, sample_u, sample_v
// out_ch   source     out_i, out_q, out_u, out_v, out_index, last_out
// cfg      write      cfg_we, cfg_index, cfg_data
// An input that closes no output bin is taken while the divider is idle.
// An input that closes a bin starts the bit-serial divide in each lane divider; no further
// input is taken until its result has moved into the output register.
// Copy mode loads the output register directly, without the divider.
// A finished result waits in the output register while inputs that yield no result enter.
// Reset restores the register defaults and clears the profile state.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fractional_bin_downsampler #(
	parameter int MAX_BINS     = fbd_pkg::MAX_BINS_DEF,
	parameter int SAMPLE_WIDTH = fbd_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [fbd_pkg::CNT_W-1:0]   cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_q,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_u,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_v,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]   out_i,
	output logic signed [SAMPLE_WIDTH-1:0]   out_q,
	output logic signed [SAMPLE_WIDTH-1:0]   out_u,
	output logic signed [SAMPLE_WIDTH-1:0]   out_v,
	output logic [fbd_pkg::IDX_W-1:0]        out_index,
	output logic                             last_out
);
	localparam int CW    = fbd_pkg::CNT_W;
	localparam int L     = fbd_pkg::LANES;
	localparam int ACC_W = SAMPLE_WIDTH + CW + 9;
	localparam int STEPS = ACC_W + 1;
	localparam int SC_W  = $clog2(STEPS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BINS > 1024 ? 1024 : MAX_BINS);

	logic            en_q;
	logic [CW-1:0]   in_bins_q, out_bins_q;
	logic [CW-1:0]   ipos_q, spos_q;
	logic [fbd_pkg::IDX_W-1:0] opos_q;
	logic signed [ACC_W-1:0] acc_q [L];
	logic [CW-1:0]   nin, nout, nout_raw, rem;
	logic signed [SAMPLE_WIDTH-1:0] smp [L];
	logic signed [SAMPLE_WIDTH-1:0] res [L];
	logic signed [ACC_W-1:0] sum_close [L];
	fbd_pkg::div_state_t st_q, st_d;
	logic [SC_W-1:0] cnt_q;
	logic            close, copy_emit, accept, div_start, div_step;
	logic [fbd_pkg::IDX_W-1:0] pidx_q;
	logic            plast_q;
	logic            obuf_v_q;

	function automatic logic [CW-1:0] eff(input logic [CW-1:0] v);
		if (v == '0) return CW'(1);
		if (v > MAXC) return MAXC;
		return v;
	endfunction

	assign smp[0] = sample_i;
	assign smp[1] = sample_q;
	assign smp[2] = sample_u;
	assign smp[3] = sample_v;

	always_comb begin
		nin       = eff(in_bins_q);
		nout_raw  = eff(out_bins_q);
		nout      = (nout_raw > nin) ? nin : nout_raw;
		rem       = nin - spos_q;
		close     = en_q && !(nout < rem);
		copy_emit = !en_q && (ipos_q < nout);
	end

	// An input that yields a result needs the output register free and the divider idle.
	assign in_ready = (st_q == fbd_pkg::DIV_IDLE) &&
		(!obuf_v_q || out_ready || !(close || copy_emit));
	assign accept   = in_valid && in_ready;
	assign div_start = accept && close;
	assign div_step  = (st_q == fbd_pkg::DIV_RUN);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			fbd_pkg::DIV_IDLE: if (div_start) st_d = fbd_pkg::DIV_RUN;
			fbd_pkg::DIV_RUN:  if (cnt_q == SC_W'(STEPS - 1)) st_d = fbd_pkg::DIV_DONE;
			fbd_pkg::DIV_DONE: if (!obuf_v_q || out_ready) st_d = fbd_pkg::DIV_IDLE;
			default:           st_d = fbd_pkg::DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= fbd_pkg::DIV_IDLE;
			cnt_q <= '0;
		end else begin
			st_q  <= st_d;
			cnt_q <= div_step ? cnt_q + SC_W'(1) : '0;
		end
	end

	for (genvar k = 0; k < L; k++) begin : g_lane
		assign sum_close[k] = acc_q[k] + ACC_W'(smp[k]) * $signed({1'b0, rem});
		fbd_lane_div #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .ACC_W(ACC_W), .CNT_W(CW)) u_div (
			.clk(clk), .start(div_start), .acc(sum_close[k]), .divisor(nin),
			.step(div_step), .result(res[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q       <= 1'b0;
			in_bins_q  <= CW'(1024);
			out_bins_q <= CW'(1024);
			ipos_q     <= '0;
			spos_q     <= '0;
			opos_q     <= '0;
			for (int k = 0; k < L; k++) acc_q[k] <= '0;
		end else if (cfg_we && cfg_index <= fbd_pkg::REG_OUT_BINS) begin
			unique case (cfg_index)
				fbd_pkg::REG_ENABLE:   en_q       <= cfg_data[0];
				fbd_pkg::REG_IN_BINS:  in_bins_q  <= cfg_data;
				fbd_pkg::REG_OUT_BINS: out_bins_q <= cfg_data;
				default: ;
			endcase
			ipos_q <= '0;
			spos_q <= '0;
			opos_q <= '0;
			for (int k = 0; k < L; k++) acc_q[k] <= '0;
		end else if (accept) begin
			if (ipos_q + CW'(1) >= nin) begin
				ipos_q <= '0;
				spos_q <= '0;
				opos_q <= '0;
				for (int k = 0; k < L; k++) acc_q[k] <= '0;
			end else begin
				ipos_q <= ipos_q + CW'(1);
				if (en_q && !close) begin
					spos_q <= spos_q + nout;
					for (int k = 0; k < L; k++)
						acc_q[k] <= acc_q[k] + ACC_W'(smp[k]) * $signed({1'b0, nout});
				end else if (close) begin
					spos_q <= nout - rem;
					opos_q <= opos_q + fbd_pkg::IDX_W'(1);
					for (int k = 0; k < L; k++)
						acc_q[k] <= ACC_W'(smp[k]) * $signed({1'b0, nout - rem});
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			pidx_q  <= opos_q;
			plast_q <= (opos_q == fbd_pkg::IDX_W'(nout - CW'(1)));
		end
	end

	// Output register: copy results load directly, averaged ones from the divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obuf_v_q <= 1'b0;
		end else begin
			if (obuf_v_q && out_ready) obuf_v_q <= 1'b0;
			if (accept && !en_q && ipos_q < nout) obuf_v_q <= 1'b1;
			if (st_q == fbd_pkg::DIV_DONE && (!obuf_v_q || out_ready)) obuf_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !en_q && ipos_q < nout) begin
			out_i     <= sample_i;
			out_q     <= sample_q;
			out_u     <= sample_u;
			out_v     <= sample_v;
			out_index <= fbd_pkg::IDX_W'(ipos_q);
			last_out  <= (ipos_q == nout - CW'(1));
		end else if (st_q == fbd_pkg::DIV_DONE && (!obuf_v_q || out_ready)) begin
			out_i     <= res[0];
			out_q     <= res[1];
			out_u     <= res[2];
			out_v     <= res[3];
			out_index <= pidx_q;
			last_out  <= plast_q;
		end
	end

	assign out_valid = obuf_v_q;

	`ASSERT_IMPL(a_no_accept_busy, clk, arst_n, st_q != fbd_pkg::DIV_IDLE, !accept,
		"input accepted while divider busy")
	`ASSERT_IMPL(a_hold_out, clk, arst_n, out_valid && !out_ready, ##1 out_valid,
		"result dropped while stalled")
	`ASSERT_ALWAYS(a_span, clk, arst_n, spos_q < nin || ipos_q == '0,
		"span offset out of range")
endmodule
`default_nettype wire

@@ sim/tb.sv @@
//------------------------------------------------------------------------------
// tb
// Self-checking testbench for fractional_bin_downsampler. The bench predicts
// every output bin from the accepted input bins, in both averaging and copy
// mode, across many bin-count settings. Each request on the output channel is
// checked against the oldest predicted bin. Both channels idle at random. The
// output side also holds off for one long stretch so that the input stalls.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
	localparam int SW = fbd_pkg::SAMPLE_WIDTH_DEF;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		logic signed [SW-1:0] i;
		logic signed [SW-1:0] q;
		logic signed [SW-1:0] u;
		logic signed [SW-1:0] v;
	} bin_in_t;

	typedef struct packed {
		logic signed [SW-1:0] i;
		logic signed [SW-1:0] q;
		logic signed [SW-1:0] u;
		logic signed [SW-1:0] v;
		logic [fbd_pkg::IDX_W-1:0] index;
		logic                 last;
	} bin_out_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [fbd_pkg::CNT_W-1:0] cfg_data;

	fbd_stream_if #(.payload_t(bin_in_t)) in_ch ();
	fbd_stream_if #(.payload_t(bin_out_t)) out_ch ();

	fractional_bin_downsampler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.sample_i  (in_ch.data.i),
		.sample_q  (in_ch.data.q),
		.sample_u  (in_ch.data.u),
		.sample_v  (in_ch.data.v),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_i     (out_ch.data.i),
		.out_q     (out_ch.data.q),
		.out_u     (out_ch.data.u),
		.out_v     (out_ch.data.v),
		.out_index (out_ch.data.index),
		.last_out  (out_ch.data.last)
	);

	// Register shadow and profile state of the predictor.
	logic        avg_mode;
	logic [10:0] in_count;
	logic [10:0] out_count;
	int unsigned in_pos;
	int unsigned out_pos;
	int unsigned span_fill;
	longint      lane_sum [4];

	bin_in_t  pending_bins[$];
	bin_out_t predicted_bins[$];

	int  bins_sent;
	int  bins_checked;
	int  mismatches;
	int  phases;
	bit  no_idle;
	bit  hold_arm;
	bit  hold_done;
	int  hold_left;
	int  in_gap;
	int  out_gap;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned bin_limit(logic [10:0] v);
		if (v == 0)
			return 1;
		if (v > fbd_pkg::MAX_BINS_DEF)
			return fbd_pkg::MAX_BINS_DEF;
		return v;
	endfunction

	function automatic logic [SW-1:0] scale_round(longint acc, int unsigned d);
		longint mag;
		longint q;
		longint maxv;
		maxv = (longint'(1) << (SW - 1)) - 1;
		mag = acc < 0 ? -acc : acc;
		q = (mag + d / 2) / d;
		if (acc < 0)
			q = -q;
		if (q > maxv)
			q = maxv;
		if (q < -maxv - 1)
			q = -maxv - 1;
		return q[SW-1:0];
	endfunction

	function automatic void clear_profile();
		in_pos = 0;
		out_pos = 0;
		span_fill = 0;
		for (int k = 0; k < 4; k++)
			lane_sum[k] = 0;
	endfunction

	function automatic void resample_bin(bin_in_t b);
		int unsigned nin;
		int unsigned nout;
		int unsigned rem;
		int unsigned left;
		longint s [4];
		bin_out_t r;
		nin = bin_limit(in_count);
		nout = bin_limit(out_count);
		if (nout > nin)
			nout = nin;
		s[0] = b.i;
		s[1] = b.q;
		s[2] = b.u;
		s[3] = b.v;
		if (!avg_mode) begin
			if (in_pos < nout) begin
				r.i = b.i;
				r.q = b.q;
				r.u = b.u;
				r.v = b.v;
				r.index = in_pos[fbd_pkg::IDX_W-1:0];
				r.last = (in_pos == nout - 1);
				predicted_bins.push_back(r);
			end
		end else begin
			rem = nin - span_fill;
			if (nout < rem) begin
				for (int k = 0; k < 4; k++)
					lane_sum[k] += s[k] * longint'(nout);
				span_fill += nout;
			end else begin
				left = nout - rem;
				for (int k = 0; k < 4; k++)
					lane_sum[k] += s[k] * longint'(rem);
				r.i = scale_round(lane_sum[0], nin);
				r.q = scale_round(lane_sum[1], nin);
				r.u = scale_round(lane_sum[2], nin);
				r.v = scale_round(lane_sum[3], nin);
				r.index = out_pos[fbd_pkg::IDX_W-1:0];
				r.last = (out_pos == nout - 1);
				predicted_bins.push_back(r);
				for (int k = 0; k < 4; k++)
					lane_sum[k] = s[k] * longint'(left);
				span_fill = left;
				out_pos++;
			end
		end
		in_pos++;
		if (in_pos >= nin)
			clear_profile();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic nv;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			in_gap = 0;
		end else begin
			nv = in_ch.valid;
			if (in_ch.valid && in_ch.ready) begin
				resample_bin(pending_bins.pop_front());
				bins_sent++;
				nv = 1'b0;
				in_gap = no_idle ? 0 : $urandom_range(0, 19);
			end
			if (!nv) begin
				if (in_gap > 0)
					in_gap--;
				else if (pending_bins.size() > 0) begin
					nv = 1'b1;
					in_ch.data <= pending_bins[0];
				end
			end
			in_ch.valid <= nv;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		bin_out_t exp_bin;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			out_gap = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				bins_checked++;
				if (predicted_bins.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected output bin %p", out_ch.data);
				end else begin
					exp_bin = predicted_bins.pop_front();
					if (out_ch.data.i !== exp_bin.i || out_ch.data.q !== exp_bin.q ||
							out_ch.data.u !== exp_bin.u || out_ch.data.v !== exp_bin.v ||
							out_ch.data.index !== exp_bin.index ||
							out_ch.data.last !== exp_bin.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected %p, got %p", exp_bin, out_ch.data);
					end
				end
				out_gap = no_idle ? 0 : $urandom_range(0, 19);
			end
			if (hold_left > 0)
				out_ch.ready <= 1'b0;
			else if (out_gap > 0) begin
				out_gap--;
				out_ch.ready <= 1'b0;
			end else
				out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (hold_arm && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	task automatic wait_idle();
		while (pending_bins.size() > 0 || predicted_bins.size() > 0 || in_ch.valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [10:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			fbd_pkg::REG_ENABLE: avg_mode = val[0];
			fbd_pkg::REG_IN_BINS: in_count = val;
			default: out_count = val;
		endcase
		clear_profile();
	endtask

	task automatic run_phase(logic en, logic [10:0] nin, logic [10:0] nout, int n, bit quiet);
		bin_in_t b;
		int pick;
		wait_idle();
		write_reg(fbd_pkg::REG_ENABLE, {10'd0, en});
		write_reg(fbd_pkg::REG_IN_BINS, nin);
		write_reg(fbd_pkg::REG_OUT_BINS, nout);
		@(negedge clk);
		no_idle = quiet;
		phases++;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 9);
			b = {$urandom, $urandom, $urandom};
			if (pick == 0)
				b = {4{1'b0, {(SW-1){1'b1}}}};
			else if (pick == 1)
				b = {4{1'b1, {(SW-1){1'b0}}}};
			else if (pick == 2)
				b.i = $urandom_range(0, 7) - 4;
			pending_bins.push_back(b);
		end
	endtask

	initial begin
		bin_in_t b;
		int unsigned nin;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = fbd_pkg::REG_ENABLE;
		cfg_data = '0;
		avg_mode = 1'b0;
		in_count = 11'd1024;
		out_count = 11'd1024;
		clear_profile();
		bins_sent = 0;
		bins_checked = 0;
		mismatches = 0;
		phases = 0;
		no_idle = 1'b0;
		hold_arm = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults: copy mode, 1024 bins each way.
		for (int k = 0; k < 4; k++) begin
			b = {$urandom, $urandom, $urandom};
			pending_bins.push_back(b);
		end
		// Bins at both full-scale ends averaged three into two, then two small bins.
		wait_idle();
		write_reg(fbd_pkg::REG_ENABLE, 11'd1);
		write_reg(fbd_pkg::REG_IN_BINS, 11'd3);
		write_reg(fbd_pkg::REG_OUT_BINS, 11'd2);
		@(negedge clk);
		pending_bins.push_back({4{1'b0, {(SW-1){1'b1}}}});
		pending_bins.push_back({4{1'b1, {(SW-1){1'b0}}}});
		pending_bins.push_back({4{1'b1, {(SW-1){1'b0}}}});
		pending_bins.push_back({4{1'b0, {(SW-1){1'b1}}}});
		pending_bins.push_back({4{24'sd1}});
		pending_bins.push_back({4{-24'sd2}});
		run_phase(1'b1, 11'd0, 11'd0, 3, 1'b0);
		run_phase(1'b1, 11'd2047, 11'd2047, 4, 1'b0);
		run_phase(1'b0, 11'd5, 11'd9, 6, 1'b0);
		run_phase(1'b0, 11'd2047, 11'd0, 4, 1'b1);

		while (bins_sent + pending_bins.size() < 1850) begin
			if (phases == 8) begin
				run_phase(1'b1, 11'd40, 11'd37, 200, 1'b1);
				@(negedge clk);
				hold_arm = 1'b1;
			end else begin
				nin = $urandom_range(1, 48);
				run_phase($urandom_range(0, 3) != 0, nin, $urandom_range(0, nin + 4),
					nin * $urandom_range(1, 3) + $urandom_range(0, 3),
					$urandom_range(0, 5) == 0);
			end
		end
		wait_idle();
		$display("Covered %0d phases of bin settings, %0d input bins, %0d output bins.",
			phases, bins_sent, bins_checked);
		if (mismatches == 0 && predicted_bins.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("Timeout with %0d output bins outstanding.", predicted_bins.size());
		$display("CHECK FAILED");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/fbd_pkg.sv
hw/rtl/fbd_stream_if.sv
hw/rtl/fbd_lane_div.sv
hw/rtl/fractional_bin_downsampler.sv
sim/tb.sv
